### rtl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  // command codes carried on the request channel
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_refill;
  } dp_status_t;

  localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

endpackage

`default_nettype wire

### rtl/cdq_in_if.sv
`default_nettype none

interface cdq_in_if
  import cdq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

### rtl/cdq_out_if.sv
`default_nettype none

interface cdq_out_if
  import cdq_pkg::*;
#(
  parameter int CNT_W = 4
) ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] popped;
  logic signed [DATA_W-1:0] front_word;
  logic signed [DATA_W-1:0] back_word;
  logic [CNT_W-1:0]         occupancy;
  logic                     is_empty;
  logic                     is_full;

  modport source (
    output valid, output status, output popped, output front_word,
    output back_word, output occupancy, output is_empty, output is_full,
    input ready
  );
  modport sink (
    input valid, input status, input popped, input front_word,
    input back_word, input occupancy, input is_empty, input is_full,
    output ready
  );
endinterface

`default_nettype wire

### rtl/circular_double_ended_queue.sv
// Double-ended queue of signed 32-bit words in a ring store of DEPTH entries.
// req channel: cmd (push front, push back, pop front, pop back, peek) and
// value; one transaction is accepted when req.valid and req.ready are high.
// rsp channel: exactly one result per request with status, popped word, the
// front and back words (-1 when empty), occupancy and empty/full flags.
// The result is registered at acceptance and offered from S_OUT; a pop that
// leaves words behind first passes through S_LOAD, since the new end word is
// fetched through the single registered read port of the ring store.
// No new request is taken while a result is pending; req.ready rises
// again the cycle after the result is taken.
// A push to a full queue is dropped with overflow status; a pop of an
// empty queue returns underflow status and changes nothing.
// When the receiver stalls the result holds steady and no request is taken.
// Reset clears the pointers and the count, so the queue starts empty; the
// ring store itself is not cleared and needs no clearing pass.
`default_nettype none

module circular_double_ended_queue
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input wire logic clk,
  input wire logic rst,
  cdq_in_if.sink   req,
  cdq_out_if.source rsp
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ctrl_cmd_t  ctrl;
  dp_status_t dp_stat;

  // sequencer
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (dp_stat),
    .cmd       (ctrl)
  );

  // pointers, ring store and result registers
  cdq_datapath #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W),
    .CNT_W (CNT_W)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .req_cmd        (req.cmd),
    .req_value      (req.value),
    .cmd            (ctrl),
    .status         (dp_stat),
    .rsp_status     (rsp.status),
    .rsp_popped     (rsp.popped),
    .rsp_front_word (rsp.front_word),
    .rsp_back_word  (rsp.back_word),
    .rsp_occupancy  (rsp.occupancy),
    .rsp_is_empty   (rsp.is_empty),
    .rsp_is_full    (rsp.is_full)
  );

endmodule

`default_nettype wire

### rtl/cdq_ctrl.sv
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = status.need_refill ? S_LOAD : S_OUT;
        end
      end
      S_LOAD: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    req_ready  = (state == S_IDLE);
    rsp_valid  = (state == S_OUT);
    cmd.accept = (state == S_IDLE) && req_valid;
    cmd.load   = (state == S_LOAD);
  end

endmodule

`default_nettype wire

### rtl/cdq_datapath.sv
`default_nettype none

module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int PTR_W = 3,
  parameter int CNT_W = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [CMD_W-1:0]         req_cmd,
  input  wire logic signed [DATA_W-1:0] req_value,
  input  wire ctrl_cmd_t                cmd,
  output dp_status_t                    status,
  output logic [STATUS_W-1:0]           rsp_status,
  output logic signed [DATA_W-1:0]      rsp_popped,
  output logic signed [DATA_W-1:0]      rsp_front_word,
  output logic signed [DATA_W-1:0]      rsp_back_word,
  output logic [CNT_W-1:0]              rsp_occupancy,
  output logic                          rsp_is_empty,
  output logic                          rsp_is_full
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [DATA_W-1:0] ring_store [DEPTH];
  logic [DATA_W-1:0] rd_data;

  logic [PTR_W-1:0]  head_ptr, head_ptr_next;
  logic [PTR_W-1:0]  tail_ptr, tail_ptr_next;
  logic [CNT_W-1:0]  held_count, held_count_next;
  logic [DATA_W-1:0] front_cache, front_cache_next;
  logic [DATA_W-1:0] back_cache, back_cache_next;
  logic              refill_front, refill_front_next;
  logic [STATUS_W-1:0] result_status, result_status_next;
  logic [DATA_W-1:0] result_popped, result_popped_next;

  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [PTR_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;
  logic              cnt_empty, cnt_full, cnt_last;

  // ring pointer neighbors
  always_comb begin
    head_inc  = (head_ptr == PTR_LAST) ? '0 : head_ptr + 1'b1;
    head_dec  = (head_ptr == '0) ? PTR_LAST : head_ptr - 1'b1;
    tail_inc  = (tail_ptr == PTR_LAST) ? '0 : tail_ptr + 1'b1;
    tail_dec  = (tail_ptr == '0) ? PTR_LAST : tail_ptr - 1'b1;
    cnt_empty = (held_count == '0);
    cnt_full  = (held_count == CNT_FULL);
    cnt_last  = (held_count == CNT_W'(1));
  end

  // command decode and next state of the queue
  always_comb begin
    head_ptr_next      = head_ptr;
    tail_ptr_next      = tail_ptr;
    held_count_next    = held_count;
    front_cache_next   = front_cache;
    back_cache_next    = back_cache;
    refill_front_next  = refill_front;
    result_status_next = ST_DONE;
    result_popped_next = '0;
    wr_en              = 1'b0;
    wr_addr            = '0;
    rd_addr            = '0;
    status.need_refill = 1'b0;
    unique case (req_cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (cnt_full) begin
          result_status_next = ST_OVERFLOW;
        end else begin
          wr_en           = 1'b1;
          held_count_next = held_count + 1'b1;
          priority if (cnt_empty) begin
            head_ptr_next    = '0;
            tail_ptr_next    = '0;
            wr_addr          = '0;
            front_cache_next = req_value;
            back_cache_next  = req_value;
          end else if (req_cmd == CMD_PUSH_FRONT) begin
            head_ptr_next    = head_dec;
            wr_addr          = head_dec;
            front_cache_next = req_value;
          end else begin
            tail_ptr_next   = tail_inc;
            wr_addr         = tail_inc;
            back_cache_next = req_value;
          end
        end
      end
      CMD_POP_FRONT: begin
        if (cnt_empty) begin
          result_status_next = ST_UNDERFLOW;
        end else begin
          result_popped_next = front_cache;
          held_count_next    = held_count - 1'b1;
          if (!cnt_last) begin
            head_ptr_next      = head_inc;
            rd_addr            = head_inc;
            refill_front_next  = 1'b1;
            status.need_refill = 1'b1;
          end
        end
      end
      CMD_POP_BACK: begin
        if (cnt_empty) begin
          result_status_next = ST_UNDERFLOW;
        end else begin
          result_popped_next = back_cache;
          held_count_next    = held_count - 1'b1;
          if (!cnt_last) begin
            tail_ptr_next      = tail_dec;
            rd_addr            = tail_dec;
            refill_front_next  = 1'b0;
            status.need_refill = 1'b1;
          end
        end
      end
      default: begin
        // peek and unused codes leave the queue alone
      end
    endcase
    rd_en = cmd.accept && status.need_refill;
  end

  // ring store, one write or one registered read per transaction
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      ring_store[wr_addr] <= req_value;
    end
    if (rd_en) begin
      rd_data <= ring_store[rd_addr];
    end
  end

  // pointer and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr   <= '0;
      tail_ptr   <= '0;
      held_count <= '0;
    end else if (cmd.accept) begin
      head_ptr   <= head_ptr_next;
      tail_ptr   <= tail_ptr_next;
      held_count <= held_count_next;
    end
  end

  // end-word cache and result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      front_cache   <= front_cache_next;
      back_cache    <= back_cache_next;
      refill_front  <= refill_front_next;
      result_status <= result_status_next;
      result_popped <= result_popped_next;
    end else if (cmd.load) begin
      if (refill_front) begin
        front_cache <= rd_data;
      end else begin
        back_cache <= rd_data;
      end
    end
  end

  // result fields
  always_comb begin
    rsp_status     = result_status;
    rsp_popped     = result_popped;
    rsp_front_word = cnt_empty ? EMPTY_WORD : front_cache;
    rsp_back_word  = cnt_empty ? EMPTY_WORD : back_cache;
    rsp_occupancy  = held_count;
    rsp_is_empty   = cnt_empty;
    rsp_is_full    = cnt_full;
  end

endmodule

`default_nettype wire

### rtl/cdq_checker.sv
`default_nettype none

module cdq_checker
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int CNT_W = 4
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_ready,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire logic [STATUS_W-1:0] rsp_status,
  input wire logic [DATA_W-1:0]   rsp_front_word,
  input wire logic [DATA_W-1:0]   rsp_back_word,
  input wire logic [CNT_W-1:0]    rsp_occupancy,
  input wire logic                rsp_is_empty,
  input wire logic                rsp_is_full
);

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // no new request while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken with result pending");

  // empty queue reports -1 at both ends
  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_is_empty |->
      rsp_front_word == EMPTY_WORD && rsp_back_word == EMPTY_WORD
      && rsp_occupancy == '0)
    else $error("empty result with stale end words");

  // overflow only when full, underflow only when empty
  a_status_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |->
      (rsp_status != ST_OVERFLOW || rsp_is_full)
      && (rsp_status != ST_UNDERFLOW || rsp_is_empty)
      && rsp_occupancy <= CNT_W'(DEPTH))
    else $error("status disagrees with occupancy");

endmodule

bind circular_double_ended_queue cdq_checker #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_cdq_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_front_word (rsp.front_word),
  .rsp_back_word  (rsp.back_word),
  .rsp_occupancy  (rsp.occupancy),
  .rsp_is_empty   (rsp.is_empty),
  .rsp_is_full    (rsp.is_full)
);

`default_nettype wire
